FILE: design/page_free_list_allocator_core_assert.svh
// Assertion macros for the page free list allocator.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef PAGE_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PFLA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfla assertion failed");
`define PFLA_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfla assertion failed");
`else
`define PFLA_ASSERT_IMP(name, clk, rst, ante, cons)
`define PFLA_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: design/pfla_pkg.sv
// Shared types and constants of the page free list allocator.
// No dependencies; used by pfla_ctrl, pfla_dp and the top level.
package pfla_pkg;

  localparam int ADDR_W         = 48;
  localparam int DEF_MAX_PAGES  = 16384;
  localparam int DEF_PAGE_SHIFT = 12;
  localparam int OP_W           = 2;
  localparam int STATUS_W       = 3;
  localparam int COUNT_W        = 15;
  localparam int APB_AW         = 4;
  localparam int APB_DW         = 64;
  localparam int REG_SEL_BIT    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_PAGE  = 3'd1,
    ST_NOT_INIT = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef enum logic {
    REG_BASE = 1'b0,
    REG_SIZE = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE_CHK,
    S_FREE_WB,
    S_INIT_SUM,
    S_INIT_CHK,
    S_INIT_FILL,
    S_INIT_DONE,
    S_OTHER
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    rd_head;
    logic    alloc_commit;
    logic    free_check;
    logic    free_commit;
    logic    init_sum;
    logic    init_span;
    logic    fill_step;
    logic    init_commit;
    logic    load_out;
    logic    page_sel;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic ready_flag;
    logic list_empty;
    logic addr_zero;
    logic in_range;
    logic in_use;
    logic init_empty;
    logic fill_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: design/pfla_ctrl.sv
// Controller state machine of the page free list allocator.
// Depends on pfla_pkg; drives pfla_dp through dp_cmd_t, reads dp_stat_t.
module pfla_ctrl import pfla_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] op,
  output logic            in_ready,
  input  dp_stat_t        st,
  output dp_cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = ST_OK;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.rd_head = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (op_t'(op))
            OP_INIT:  state_next = S_INIT_SUM;
            OP_ALLOC: state_next = S_ALLOC;
            OP_FREE:  state_next = S_FREE_CHK;
            default:  state_next = S_OTHER;
          endcase
        end
      end
      S_ALLOC: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
          priority if (!st.ready_flag) begin
            cmd.status = ST_NOT_INIT;
          end else if (st.list_empty) begin
            cmd.status = ST_NO_PAGE;
          end else begin
            cmd.alloc_commit = 1'b1;
            cmd.page_sel     = 1'b1;
            cmd.status       = ST_OK;
          end
        end
      end
      S_FREE_CHK: begin
        priority if (!st.ready_flag) begin
          cmd.status = ST_NOT_INIT;
          if (st.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (st.addr_zero || !st.in_range) begin
          cmd.status = ST_IGNORED;
          if (st.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.free_check = 1'b1;
          state_next     = S_FREE_WB;
        end
      end
      S_FREE_WB: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
          if (st.in_use) begin
            cmd.free_commit = 1'b1;
            cmd.status      = ST_OK;
          end else begin
            cmd.status = ST_IGNORED;
          end
        end
      end
      S_INIT_SUM: begin
        cmd.init_sum = 1'b1;
        state_next   = S_INIT_CHK;
      end
      S_INIT_CHK: begin
        if (st.init_empty) begin
          cmd.status = ST_REJECTED;
          if (st.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.init_span = 1'b1;
          state_next    = S_INIT_FILL;
        end
      end
      S_INIT_FILL: begin
        cmd.fill_step = 1'b1;
        if (st.fill_last) begin
          state_next = S_INIT_DONE;
        end
      end
      S_INIT_DONE: begin
        if (st.out_free) begin
          cmd.init_commit = 1'b1;
          cmd.load_out    = 1'b1;
          cmd.status      = ST_OK;
          state_next      = S_IDLE;
        end
      end
      S_OTHER: begin
        cmd.status = ST_IGNORED;
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/pfla_dp.sv
// Datapath of the page free list allocator: link memory, list registers,
// address arithmetic and the result register. Depends on pfla_pkg.
module pfla_dp import pfla_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ADDR_W-1:0]   region_base,
  input  logic [ADDR_W-1:0]   region_size,
  input  logic [ADDR_W-1:0]   free_address,
  input  dp_cmd_t             cmd,
  output dp_stat_t            st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ADDR_W-1:0]   page_address,
  output logic [COUNT_W-1:0]  pages_free,
  output logic [COUNT_W-1:0]  pages_total
);

  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int PN_W  = ADDR_W - PAGE_SHIFT;
  localparam logic [CNT_W-1:0]  LINK_EMPTY = CNT_W'(MAX_PAGES);
  localparam logic [ADDR_W-1:0] PAGE_MASK  = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  // entry: {in_use, link}
  logic [CNT_W:0]      mem [MAX_PAGES];
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [CNT_W:0]      mem_wd;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_ra;
  logic [CNT_W:0]      rd_data;

  logic [CNT_W-1:0]    head;
  logic [CNT_W-1:0]    free_cnt;
  logic [CNT_W-1:0]    total_cnt;
  logic [PN_W-1:0]     top_pn;
  logic                ready_flag;

  logic [PN_W-1:0]     diff;
  logic                addr_zero;
  logic [IDX_W-1:0]    slot;
  logic [PN_W-1:0]     init_base_pn;
  logic [PN_W-1:0]     init_top_pn;
  logic [CNT_W-1:0]    n_pages;
  logic [IDX_W-1:0]    fill_idx;

  logic [CNT_W-1:0]    free_next;
  logic [CNT_W-1:0]    total_next;
  logic [PN_W-1:0]     page_pn;
  logic [PN_W-1:0]     span;
  logic [IDX_W-1:0]    slot_c;
  logic [ADDR_W-1:0]   base_sum;
  logic [ADDR_W-1:0]   top_sum;
  logic [CNT_W-1:0]    fill_link;

  assign span      = init_top_pn - init_base_pn;
  assign slot_c    = IDX_W'(diff - PN_W'(1));
  assign page_pn   = top_pn + ~PN_W'(head);
  assign base_sum  = region_base + PAGE_MASK;
  assign top_sum   = region_base + region_size;
  assign fill_link = (fill_idx == '0) ? LINK_EMPTY : CNT_W'(fill_idx) - CNT_W'(1);

  assign st.ready_flag = ready_flag;
  assign st.list_empty = (head == LINK_EMPTY) || (free_cnt == '0);
  assign st.addr_zero  = addr_zero;
  assign st.in_range   = (diff != '0) && (diff <= PN_W'(total_cnt));
  assign st.in_use     = rd_data[CNT_W];
  assign st.init_empty = (init_top_pn <= init_base_pn);
  assign st.fill_last  = (CNT_W'(fill_idx) == n_pages - CNT_W'(1));
  assign st.out_free   = !out_valid || out_ready;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill_idx;
    mem_wd = {1'b0, fill_link};
    priority if (cmd.alloc_commit) begin
      mem_we = 1'b1;
      mem_wa = head[IDX_W-1:0];
      mem_wd = {1'b1, LINK_EMPTY};
    end else if (cmd.free_commit) begin
      mem_we = 1'b1;
      mem_wa = slot;
      mem_wd = {1'b0, head};
    end else if (cmd.fill_step) begin
      mem_we = 1'b1;
    end
    mem_re = (cmd.rd_head && (head != LINK_EMPTY)) || cmd.free_check;
    mem_ra = cmd.free_check ? slot_c : head[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_comb begin
    free_next  = free_cnt;
    total_next = total_cnt;
    priority if (cmd.alloc_commit) begin
      free_next = free_cnt - CNT_W'(1);
    end else if (cmd.free_commit) begin
      free_next = free_cnt + CNT_W'(1);
    end else if (cmd.init_commit) begin
      free_next  = n_pages;
      total_next = n_pages;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= LINK_EMPTY;
      free_cnt   <= '0;
      total_cnt  <= '0;
      top_pn     <= '0;
      ready_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      free_cnt  <= free_next;
      total_cnt <= total_next;
      priority if (cmd.alloc_commit) begin
        head <= rd_data[CNT_W-1:0];
      end else if (cmd.free_commit) begin
        head <= CNT_W'(slot);
      end else if (cmd.init_commit) begin
        head       <= n_pages - CNT_W'(1);
        top_pn     <= init_top_pn;
        ready_flag <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff      <= top_pn - free_address[ADDR_W-1:PAGE_SHIFT];
      addr_zero <= (free_address == '0);
    end
    if (cmd.free_check) begin
      slot <= slot_c;
    end
    if (cmd.init_sum) begin
      init_base_pn <= base_sum[ADDR_W-1:PAGE_SHIFT];
      init_top_pn  <= top_sum[ADDR_W-1:PAGE_SHIFT];
    end
    if (cmd.init_span) begin
      n_pages  <= (span > PN_W'(MAX_PAGES)) ? LINK_EMPTY : CNT_W'(span);
      fill_idx <= '0;
    end else if (cmd.fill_step) begin
      fill_idx <= fill_idx + IDX_W'(1);
    end
    if (cmd.load_out) begin
      status       <= cmd.status;
      page_address <= cmd.page_sel ? {page_pn, {PAGE_SHIFT{1'b0}}} : '0;
      pages_free   <= COUNT_W'(free_next);
      pages_total  <= COUNT_W'(total_next);
    end
  end

endmodule

FILE: design/page_free_list_allocator_core.sv
// Page free list allocator: hands out and takes back whole DRAM pages.
// Input beats carry op and free_address; every beat yields one output beat
// with status, page_address, pages_free and pages_total.
// Set region_base (offset 0x0) and region_size (offset 0x8) on the APB port
// while idle, then send an init beat. Init fills the link memory one page
// per cycle in S_INIT_FILL; a rejected init is answered from S_INIT_CHK.
// Alloc reads the head entry while idle and answers from S_ALLOC; free
// reads its slot in S_FREE_CHK and writes it back in S_FREE_WB, or answers
// from S_FREE_CHK when it is ignored or comes before init; both follow the
// registered read of the link memory. S_OTHER answers undefined ops.
// in_ready is high whenever the controller is idle, even while a result
// waits; a stalled output holds the next item in its last step until the
// result register drains. Reset empties the list, clears the counts and the
// registers; alloc and free report not initialized until init runs.
// Depends on pfla_pkg, pfla_ctrl, pfla_dp and the assertion macro header.
`include "page_free_list_allocator_core_assert.svh"
module page_free_list_allocator_core import pfla_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [ADDR_W-1:0]   free_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ADDR_W-1:0]   page_address,
  output logic [COUNT_W-1:0]  pages_free,
  output logic [COUNT_W-1:0]  pages_total
);

  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W-1:0] region_size;
  reg_idx_t          reg_sel;
  logic              reg_wr;
  dp_cmd_t           cmd;
  dp_stat_t          dp_st;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[REG_SEL_BIT]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_size <= '0;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_BASE: region_base <= pwdata[ADDR_W-1:0];
        REG_SIZE: region_size <= pwdata[ADDR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE: prdata = {{(APB_DW-ADDR_W){1'b0}}, region_base};
      REG_SIZE: prdata = {{(APB_DW-ADDR_W){1'b0}}, region_size};
    endcase
  end

  pfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .st       (dp_st),
    .cmd      (cmd)
  );

  pfla_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .region_base  (region_base),
    .region_size  (region_size),
    .free_address (free_address),
    .cmd          (cmd),
    .st           (dp_st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .page_address (page_address),
    .pages_free   (pages_free),
    .pages_total  (pages_total)
  );

  `PFLA_ASSERT_IMP(a_commit_replies, clk, rst,
                   cmd.alloc_commit || cmd.free_commit || cmd.init_commit, cmd.load_out)
  `PFLA_ASSERT_IMP(a_one_write, clk, rst, 1'b1,
                   $onehot0({cmd.alloc_commit, cmd.free_commit, cmd.fill_step}))
  `PFLA_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.load_out, dp_st.out_free)
  `PFLA_ASSERT_NXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)

endmodule

FILE: verif/pfla_tb_pkg.sv
// Scoreboard for the page free list allocator testbench: a page allocator
// predictor plus the queue of expected output beats. Depends on pfla_pkg.
package pfla_tb_pkg;
  import pfla_pkg::*;

  localparam int unsigned          SLOT_COUNT = DEF_MAX_PAGES;
  localparam int                   PG_SHIFT   = DEF_PAGE_SHIFT;
  localparam logic [ADDR_W-1:0]    PG_BYTES   = ADDR_W'(1) << PG_SHIFT;
  localparam logic [ADDR_W-1:0]    PG_OFFSET  = PG_BYTES - ADDR_W'(1);
  localparam logic [COUNT_W-1:0]   SLOT_NONE  = COUNT_W'(DEF_MAX_PAGES);

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   page_address;
    logic [COUNT_W-1:0]  pages_free;
    logic [COUNT_W-1:0]  pages_total;
  } alloc_reply_t;

  class alloc_scoreboard;
    bit [ADDR_W-1:0]  region_base;
    bit [ADDR_W-1:0]  region_size;
    bit [ADDR_W-1:0]  region_top;
    bit [COUNT_W-1:0] next_slot [SLOT_COUNT];
    bit               in_use [SLOT_COUNT];
    bit [COUNT_W-1:0] head;
    bit [COUNT_W-1:0] n_free;
    bit [COUNT_W-1:0] n_total;
    bit               initialized;
    alloc_reply_t     expected_replies [$];
    int               errors;
    int               accepted;

    function new();
      region_base = '0;
      region_size = '0;
      region_top  = '0;
      head        = SLOT_NONE;
      n_free      = '0;
      n_total     = '0;
      initialized = 1'b0;
      errors      = 0;
      accepted    = 0;
    endfunction

    function void set_register(reg_idx_t idx, bit [ADDR_W-1:0] value);
      if (idx == REG_BASE) begin
        region_base = value;
      end else begin
        region_size = value;
      end
    endfunction

    function alloc_reply_t reply(status_t st, bit [ADDR_W-1:0] page);
      alloc_reply_t r;
      r.status       = st;
      r.page_address = page;
      r.pages_free   = n_free;
      r.pages_total  = n_total;
      return r;
    endfunction

    function bit [ADDR_W-1:0] slot_page(int unsigned slot);
      return region_top - ((ADDR_W'(slot) + ADDR_W'(1)) << PG_SHIFT);
    endfunction

    function alloc_reply_t predict_init();
      bit [ADDR_W-1:0] lo;
      bit [ADDR_W-1:0] hi;
      bit [ADDR_W-1:0] span;
      int unsigned     n;
      int unsigned     i;
      lo = (region_base + PG_OFFSET) & ~PG_OFFSET;
      hi = (region_base + region_size) & ~PG_OFFSET;
      if (hi <= lo) return reply(ST_REJECTED, '0);
      span = (hi - lo) >> PG_SHIFT;
      n = (span > ADDR_W'(SLOT_COUNT)) ? SLOT_COUNT : int'(span);
      for (i = 0; i < n; i++) begin
        next_slot[i] = (i == 0) ? SLOT_NONE : COUNT_W'(i - 1);
        in_use[i]    = 1'b0;
      end
      head        = COUNT_W'(n - 1);
      n_free      = COUNT_W'(n);
      n_total     = COUNT_W'(n);
      region_top  = hi;
      initialized = 1'b1;
      return reply(ST_OK, '0);
    endfunction

    function alloc_reply_t predict_alloc();
      int unsigned slot;
      if (!initialized) return reply(ST_NOT_INIT, '0);
      if (head >= SLOT_NONE || n_free == 0) return reply(ST_NO_PAGE, '0);
      slot            = head;
      head            = next_slot[slot];
      next_slot[slot] = SLOT_NONE;
      in_use[slot]    = 1'b1;
      n_free          = n_free - 1'b1;
      return reply(ST_OK, slot_page(slot));
    endfunction

    function alloc_reply_t predict_free(bit [ADDR_W-1:0] raw);
      bit [ADDR_W-1:0] phys;
      bit [ADDR_W-1:0] lowest;
      bit [ADDR_W-1:0] delta;
      int unsigned     slot;
      if (!initialized) return reply(ST_NOT_INIT, '0);
      if (raw == 0) return reply(ST_IGNORED, '0);
      phys   = raw & ~PG_OFFSET;
      lowest = region_top - (ADDR_W'(n_total) << PG_SHIFT);
      if (phys < lowest || phys >= region_top) return reply(ST_IGNORED, '0);
      delta = (region_top - PG_BYTES - phys) >> PG_SHIFT;
      if (delta >= ADDR_W'(SLOT_COUNT)) return reply(ST_IGNORED, '0);
      slot = int'(delta);
      // already free: must not be pushed a second time
      if (!in_use[slot]) return reply(ST_IGNORED, '0);
      in_use[slot]    = 1'b0;
      next_slot[slot] = head;
      head            = COUNT_W'(slot);
      n_free          = n_free + 1'b1;
      return reply(ST_OK, '0);
    endfunction

    function void note_request(bit [OP_W-1:0] op, bit [ADDR_W-1:0] addr);
      alloc_reply_t r;
      case (op)
        OP_INIT:  r = predict_init();
        OP_ALLOC: r = predict_alloc();
        OP_FREE:  r = predict_free(addr);
        default:  r = reply(ST_IGNORED, '0);
      endcase
      accepted++;
      expected_replies.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_response(bit [STATUS_W-1:0] st, bit [ADDR_W-1:0] page,
                        bit [COUNT_W-1:0] nf, bit [COUNT_W-1:0] nt);
      alloc_reply_t e;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("output beat with nothing expected, status %0d", st));
        return;
      end
      e = expected_replies.pop_front();
      if (st != e.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
      if (page != e.page_address)
        report_mismatch($sformatf("page_address %h, expected %h", page, e.page_address));
      if (nf != e.pages_free)
        report_mismatch($sformatf("pages_free %0d, expected %0d", nf, e.pages_free));
      if (nt != e.pages_total)
        report_mismatch($sformatf("pages_total %0d, expected %0d", nt, e.pages_total));
    endtask

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

endpackage

FILE: verif/tb_top.sv
// Top of the page free list allocator testbench: clock, reset, APB register
// writes, paced request beats, stalled result beats and the final verdict.
// Depends on pfla_pkg, pfla_tb_pkg and page_free_list_allocator_core.
module tb_top;
  import pfla_pkg::*;
  import pfla_tb_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEF     = 2'd3;
  localparam int              RESET_CYCLES = 8;
  localparam int              SETTLE       = 10;
  localparam int              RANDOM_ITEMS = 1450;
  localparam int              CYCLE_LIMIT  = 1000000;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op = '0;
  logic [ADDR_W-1:0]   free_address = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   page_address;
  logic [COUNT_W-1:0]  pages_free;
  logic [COUNT_W-1:0]  pages_total;

  alloc_scoreboard sb = new();
  int              cycles = 0;
  int              burst_left = 0;
  int              rx_left = 0;
  rx_mode_t        rx_mode = RX_OPEN;
  bit              big_done = 1'b0;

  page_free_list_allocator_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(op, free_address);
      if (out_valid && out_ready)
        sb.check_response(status, page_address, pages_free, pages_total);
    end
  end

  // result side stalls on its own schedule
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (cycles % 7) >= 3;
    endcase
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ADDR_W-1:0] pick_free_address();
    int unsigned       pick;
    int unsigned       slot;
    int unsigned       tries;
    logic [ADDR_W-1:0] lowest;
    pick   = $urandom_range(0, 99);
    lowest = sb.region_top - (ADDR_W'(sb.n_total) << PG_SHIFT);
    if (pick < 75 && sb.n_total != 0) begin
      slot = $urandom_range(0, sb.n_total - 1);
      for (tries = 0; tries < 4 && !sb.in_use[slot]; tries++)
        slot = $urandom_range(0, sb.n_total - 1);
      return sb.slot_page(slot) | ADDR_W'($urandom_range(0, (1 << PG_SHIFT) - 1));
    end
    if (pick < 80) return '0;
    if (pick < 87) return lowest - ADDR_W'($urandom_range(1, 3 << PG_SHIFT));
    if (pick < 94) return sb.region_top + ADDR_W'($urandom_range(0, 3 << PG_SHIFT));
    return rand_addr();
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic issue(logic [OP_W-1:0] o, logic [ADDR_W-1:0] a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    op           <= o;
    free_address <= a;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [ADDR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << REG_SEL_BIT;
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic configure(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size);
    drain_replies();
    write_reg(REG_BASE, base);
    write_reg(REG_SIZE, size);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_region();
    int unsigned       kind;
    int unsigned       n;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    kind = $urandom_range(0, 99);
    base = rand_addr() >> 1;
    if ($urandom_range(0, 1)) base = base & ~PG_OFFSET;
    n = $urandom_range(1, 48);
    if (kind < 8) begin
      size = ADDR_W'($urandom_range(0, (1 << PG_SHIFT) - 1));
    end else if (kind < 12) begin
      // end address wraps below the base
      base = rand_addr() | (ADDR_W'(1) << (ADDR_W - 1));
      size = rand_addr() | (ADDR_W'(1) << (ADDR_W - 1));
    end else if (kind < 18) begin
      // region straddles the top of the address space
      base = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 8191));
      size = (ADDR_W'(n) << PG_SHIFT) + ADDR_W'($urandom_range(0, (1 << PG_SHIFT) - 1));
    end else if (kind < 20 && !big_done) begin
      big_done = 1'b1;
      base = rand_addr() >> 2;
      size = ADDR_W'(1) << 40;
    end else begin
      if (kind < 30) n = $urandom_range(49, 1024);
      size = (ADDR_W'(n) << PG_SHIFT) + ADDR_W'($urandom_range(0, (1 << PG_SHIFT) - 1));
    end
    configure(base, size);
  endtask

  task automatic run_directed();
    // registers still at reset: nothing initialized, empty region
    issue(OP_ALLOC, rand_addr());
    issue(OP_FREE, 48'h5000);
    issue(OP_UNDEF, rand_addr());
    issue(OP_INIT, '0);
    // unaligned base: three pages 0x2000..0x4fff
    configure(48'h1234, 48'h4000);
    issue(OP_INIT, '1);
    repeat (4) issue(OP_ALLOC, rand_addr());
    issue(OP_FREE, '0);
    issue(OP_FREE, 48'h1FFF);
    issue(OP_FREE, 48'h5000);
    issue(OP_FREE, 48'h2ABC);
    issue(OP_FREE, 48'h2000);
    issue(OP_FREE, 48'h3FFF);
    issue(OP_ALLOC, '0);
    // less than a page: init rejected, old list stays live
    configure(48'h10, 48'h800);
    issue(OP_INIT, rand_addr());
    issue(OP_ALLOC, rand_addr());
    // all ones: full page count
    configure('1, '1);
    issue(OP_INIT, rand_addr());
    issue(OP_ALLOC, rand_addr());
    issue(OP_FREE, '1);
    issue(OP_FREE, sb.region_top - (ADDR_W'(sb.n_total) << PG_SHIFT) + 48'h123);
    // base rounds up past the top of the space to zero
    configure(48'hFFFF_FFFF_FF9C, 48'h10000);
    issue(OP_INIT, rand_addr());
    issue(OP_ALLOC, rand_addr());
    issue(OP_FREE, '0);
    issue(OP_FREE, 48'h7);
  endtask

  task automatic run_random();
    int goal;
    int phase_items;
    int alloc_weight;
    int r;
    goal = sb.accepted + RANDOM_ITEMS;
    while (sb.accepted < goal) begin
      random_region();
      if ($urandom_range(0, 19) != 0) issue(OP_INIT, rand_addr());
      alloc_weight = $urandom_range(30, 70);
      phase_items  = $urandom_range(10, 70);
      repeat (phase_items) begin
        r = $urandom_range(0, 99);
        if (r < alloc_weight) issue(OP_ALLOC, rand_addr());
        else if (r < 95) issue(OP_FREE, pick_free_address());
        else if (r < 97) issue(OP_INIT, rand_addr());
        else issue(OP_UNDEF, rand_addr());
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain_replies();
    run_directed();
    run_random();
    drain_replies();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/pfla_pkg.sv
design/pfla_ctrl.sv
design/pfla_dp.sv
design/page_free_list_allocator_core.sv
verif/pfla_tb_pkg.sv
verif/tb_top.sv
